[src/brb_pkg.sv]
package brb_pkg;

  localparam int FUNC_W = 3;
  localparam int SYM_W  = 8;
  localparam int OFF_W  = 10;
  localparam int SPAN_W = 11;
  localparam int CRC_W  = 16;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 10;
  // crc positions run up to offset + span - 1
  localparam int POS_W  = 12;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam logic [SYM_W-1:0] EMPTY_BYTE = 8'hFF;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CRC   = 3'd4;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_CRC,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SYM_W-1:0]  symbol;
    logic [OFF_W-1:0]  offset;
    logic [SPAN_W-1:0] span;
    logic [POS_W-1:0]  crc_pos;
    logic [CRC_W-1:0]  seed;
  } cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0] data_byte;
    logic [CNT_W-1:0] fill_count;
    logic [CRC_W-1:0] crc_value;
  } result_t;

  // CRC-16/CCITT contribution of each bit of (byte ^ crc[15:8])
  localparam logic [CRC_W-1:0] CRC_TERMS [8] = '{
    16'h1021, 16'h2042, 16'h4084, 16'h8108,
    16'h1231, 16'h2462, 16'h48C4, 16'h9188
  };

  function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc, logic [SYM_W-1:0] b);
    logic [7:0]       idx;
    logic [CRC_W-1:0] term;
    idx  = b ^ crc[15:8];
    term = '0;
    for (int k = 0; k < 8; k++) begin
      if (idx[k]) term = term ^ CRC_TERMS[k];
    end
    return {crc[7:0], 8'h00} ^ term;
  endfunction

endpackage

[src/brb_in_if.sv]
interface brb_in_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;
  logic [OFF_W-1:0]  offset;
  logic [SPAN_W-1:0] span;
  logic [CRC_W-1:0]  crc_seed;

  modport source (output valid, func, symbol, offset, span, crc_seed, input ready);
  modport sink   (input valid, func, symbol, offset, span, crc_seed, output ready);
endinterface

[src/brb_out_if.sv]
interface brb_out_if import brb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] data_byte;
  logic [CNT_W-1:0] fill_count;
  logic [CRC_W-1:0] crc_value;

  modport source (output valid, data_byte, fill_count, crc_value, input ready);
  modport sink   (input valid, data_byte, fill_count, crc_value, output ready);
endinterface

[src/brb_front.sv]
module brb_front import brb_pkg::*; (
  brb_in_if.sink in_ch,
  input  logic   full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  op_e op;

  always_comb begin
    unique case (in_ch.func)
      FUNC_PUT:   op = OP_PUT;
      FUNC_POP:   op = OP_POP;
      FUNC_PEEK:  op = OP_PEEK;
      FUNC_CLEAR: op = OP_CLEAR;
      FUNC_CRC:   op = OP_CRC;
      default:    op = OP_NONE;
    endcase
  end

  assign in_ch.ready = !full_i;
  assign push_o      = in_ch.valid && !full_i;

  always_comb begin
    cmd_o.op      = op;
    cmd_o.symbol  = in_ch.symbol;
    cmd_o.offset  = in_ch.offset;
    cmd_o.span    = in_ch.span;
    // highest position first; unused when span is zero
    cmd_o.crc_pos = POS_W'(in_ch.offset) + POS_W'(in_ch.span) - POS_W'(1);
    cmd_o.seed    = in_ch.crc_seed;
  end

endmodule

[src/brb_queue.sv]
module brb_queue import brb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [Q_PTR_W-1:0] ptr_next(logic [Q_PTR_W-1:0] p);
    return (32'(p) == Q_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (32'(cnt_q) == Q_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= Q_DEPTH) else $error("queue count above depth");

endmodule

[src/brb_back.sv]
module brb_back import brb_pkg::*; #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  brb_out_if.source        out_ch
);

  localparam int IDX_W  = $clog2(MAX_DEPTH);
  localparam int SZ_W   = IDX_W + 1;
  localparam int CALC_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CRC
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q, cfg_d;
  logic [IDX_W-1:0]  wr_q, wr_d;
  logic [IDX_W-1:0]  rd_q, rd_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic              mem_ok_q, mem_ok_d;
  logic              fold_vld_q, fold_vld_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [SYM_W-1:0]  mem_q [MAX_DEPTH];
  logic [SYM_W-1:0]  rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  raddr;

  logic [SZ_W-1:0]   size;
  logic [IDX_W-1:0]  fill_cur;
  logic [POS_W-1:0]  peek_pos;
  logic [CALC_W-1:0] peek_sum;
  logic [CALC_W-1:0] peek_wrap;
  logic [IDX_W-1:0]  peek_addr;
  logic              peek_ok;
  logic [SYM_W-1:0]  fold_byte;
  logic              out_free;
  logic              out_load;
  result_t           res;

  function automatic logic [IDX_W-1:0] fill_of(logic [IDX_W-1:0] w, logic [IDX_W-1:0] r,
                                               logic [SZ_W-1:0] sz);
    logic [SZ_W-1:0] t;
    if (w < r) t = sz + SZ_W'(w) - SZ_W'(r);
    else       t = SZ_W'(w) - SZ_W'(r);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] idx, logic [SZ_W-1:0] sz);
    logic [SZ_W-1:0] n;
    n = SZ_W'(idx) + SZ_W'(1);
    return (n >= sz) ? '0 : n[IDX_W-1:0];
  endfunction

  // size register of 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (cfg_q == '0)                  size = SZ_W'(1);
    else if (32'(cfg_q) > MAX_DEPTH)  size = SZ_W'(MAX_DEPTH);
    else                              size = SZ_W'(cfg_q);
  end

  assign fill_cur = fill_of(wr_q, rd_q, size);

  // offset from the read index, shared by peek and the crc walk
  assign peek_pos  = (state_q == ST_CRC) ? pos_q : POS_W'(q_cmd_i.offset);
  assign peek_ok   = CALC_W'(peek_pos) < CALC_W'(fill_cur);
  assign peek_sum  = CALC_W'(rd_q) + CALC_W'(peek_pos);
  assign peek_wrap = (peek_sum >= CALC_W'(size)) ? peek_sum - CALC_W'(size) : peek_sum;
  assign peek_addr = peek_wrap[IDX_W-1:0];

  assign fold_byte = mem_ok_q ? rdata_q : EMPTY_BYTE;
  assign out_free  = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d    = state_q;
    cfg_d      = cfg_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    crc_d      = fold_vld_q ? crc_fold(crc_q, fold_byte) : crc_q;
    fold_vld_d = 1'b0;
    pos_d      = pos_q;
    rem_d      = rem_q;
    mem_ok_d   = mem_ok_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    raddr      = rd_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    res        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.op)
            OP_PUT: begin
              if (out_free) begin
                q_pop_o        = 1'b1;
                mem_we         = 1'b1;
                wr_d           = wrap_next(wr_q, size);
                out_load       = 1'b1;
                res.fill_count = CNT_W'(fill_of(wr_d, rd_q, size));
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_pop_o  = 1'b1;
                wr_d     = '0;
                rd_d     = '0;
                out_load = 1'b1;
              end
            end
            OP_NONE: begin
              if (out_free) begin
                q_pop_o        = 1'b1;
                out_load       = 1'b1;
                res.fill_count = CNT_W'(fill_cur);
              end
            end
            OP_POP: begin
              q_pop_o  = 1'b1;
              mem_re   = 1'b1;
              raddr    = rd_q;
              rd_d     = wrap_next(rd_q, size);
              mem_ok_d = 1'b1;
              state_d  = ST_READ;
            end
            OP_PEEK: begin
              q_pop_o  = 1'b1;
              mem_re   = 1'b1;
              raddr    = peek_addr;
              mem_ok_d = peek_ok;
              state_d  = ST_READ;
            end
            OP_CRC: begin
              q_pop_o = 1'b1;
              crc_d   = q_cmd_i.seed;
              pos_d   = q_cmd_i.crc_pos;
              rem_d   = q_cmd_i.span;
              state_d = ST_CRC;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // read data holds here until the output register frees up
        if (out_free) begin
          out_load       = 1'b1;
          res.data_byte  = fold_byte;
          res.fill_count = CNT_W'(fill_cur);
          state_d        = ST_IDLE;
        end
      end
      ST_CRC: begin
        // one read issued per cycle, folded when its data lands
        if (rem_q != '0) begin
          mem_re     = 1'b1;
          raddr      = peek_addr;
          mem_ok_d   = peek_ok;
          fold_vld_d = 1'b1;
          pos_d      = pos_q - 1'b1;
          rem_d      = rem_q - 1'b1;
        end else if (out_free) begin
          out_load       = 1'b1;
          res.crc_value  = crc_d;
          res.fill_count = CNT_W'(fill_cur);
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      cfg_d = cfg_data_i;
      wr_d  = '0;
      rd_d  = '0;
    end

    out_valid_d = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);
    out_d       = out_load ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      wr_q        <= '0;
      rd_q        <= '0;
      crc_q       <= '0;
      pos_q       <= '0;
      rem_q       <= '0;
      mem_ok_q    <= 1'b0;
      fold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      mem_ok_q    <= mem_ok_d;
      fold_vld_q  <= fold_vld_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_q] <= q_cmd_i.symbol;
    if (mem_re) rdata_q <= mem_q[raddr];
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.data_byte  = out_q.data_byte;
  assign out_ch.fill_count = out_q.fill_count;
  assign out_ch.crc_value  = out_q.crc_value;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SZ_W'(wr_q) < size) && (SZ_W'(rd_q) < size))
    else $error("ring index not below buffer size");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (wr_q == '0) && (rd_q == '0))
    else $error("size write did not clear indices");

  a_crc_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC) && (rem_q != '0) |=>
      (state_q == ST_CRC) && (rem_q == $past(rem_q) - 1'b1) && fold_vld_q)
    else $error("crc walk skipped a byte");

endmodule

[src/byte_ring_buffer_with_crc16.sv]
// Byte ring buffer with CRC-16/CCITT fold over stored bytes.
// in_ch carries one command beat (func, symbol, offset, span, crc_seed);
// out_ch returns exactly one result beat per command, in order.
// cfg_we_i/cfg_data_i write the buffer size; the write also clears both
// indices and must only happen while no command is in flight.
// Commands land in a two-deep queue, so in_ch keeps taking beats while a
// result waits on out_ch; the queue fills only while the executor is busy.
// Executor steps per command (single-port store, one read per cycle):
//   put, clear, unused codes: result loaded from idle
//   pop, peek:                registered store read
//   crc:                      reads span bytes, one byte folded per cycle
// With the queue empty and out_ch ready, a command passes the queue
// register, the executor and then the output register to out_ch.
// The result sits in an output register; while out_ch.ready is low it holds
// and the executor waits, then the queue fills and in_ch.ready drops.
// Reset clears the indices and sets the size to 1024; store contents are
// undefined until written.
module byte_ring_buffer_with_crc16 import brb_pkg::*; #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  brb_in_if.sink           in_ch,
  brb_out_if.source        out_ch
);

  logic push;
  logic full;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  brb_front u_front (
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  brb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  brb_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .out_ch     (out_ch)
  );

endmodule
